@@ hdl/iidl_pkg.sv @@
// Package for the indexed insert/delete list: field widths, request kinds,
// status codes and default sizes. Depends on nothing.
package iidl_pkg;

   localparam int POS_WIDTH    = 5;
   localparam int IO_WIDTH     = 32;
   localparam int COUNT_WIDTH  = 5;
   localparam int FUNC_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;

   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   typedef logic [FUNC_WIDTH-1:0]   func_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_READ   = 2'd2;
   localparam func_type FUNC_WRITE  = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

@@ hdl/iidl_if.sv @@
// Valid/ready channel interfaces for requests and responses of the list.
// Depends on iidl_pkg.
interface iidl_req_if import iidl_pkg::*; ();
   logic                        valid;
   logic                        ready;
   func_type                    func;
   logic [POS_WIDTH-1:0]        position;
   logic signed [IO_WIDTH-1:0]  item_value;

   modport source (output valid, func, position, item_value, input ready);
   modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface iidl_rsp_if import iidl_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [IO_WIDTH-1:0]  result_value;
   status_type                  status;
   logic [COUNT_WIDTH-1:0]      element_count;

   modport source (output valid, result_value, status, element_count, input ready);
   modport sink   (input valid, result_value, status, element_count, output ready);
endinterface

@@ hdl/iidl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module iidl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/indexed_insert_delete_list.sv @@
// Steps: error to S_DONE; read via S_FETCH, S_CAP; write adds S_PUT; insert shifts the
// entries from the position up (S_INS_RD, S_INS_WR), then S_PUT; remove does S_FETCH,
// S_CAP, then shifts the later entries down (S_DEL_RD, S_DEL_WR). One transaction at a
// time: ready returns with the response; a stalled response holds the sequencer in S_DONE.
// Shift cost is set by the single RAM port pair: a read state, then a write state per entry.
// Reset (synchronous, active high) empties the list; the store needs no clearing.
module indexed_insert_delete_list import iidl_pkg::*; #(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   iidl_req_if.sink   req_ch,
   iidl_rsp_if.source rsp_ch
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INS_RD = 4'd1;
   localparam logic [3:0] S_INS_WR = 4'd2;
   localparam logic [3:0] S_PUT    = 4'd3;
   localparam logic [3:0] S_FETCH  = 4'd4;
   localparam logic [3:0] S_CAP    = 4'd5;
   localparam logic [3:0] S_DEL_RD = 4'd6;
   localparam logic [3:0] S_DEL_WR = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]             state_ff, state_in;
   func_type               func_ff, func_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic [CW-1:0]          cur_ff, cur_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [IO_WIDTH-1:0]    res_ff, res_in;
   status_type             status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IO_WIDTH-1:0]    out_value_ff, out_value_in;
   status_type             out_status_ff, out_status_in;
   logic [COUNT_WIDTH-1:0] out_count_ff, out_count_in;

   logic                   req_fire;
   logic                   slot_free;
   logic [CMPW-1:0]        pos_x, cnt_x;
   logic [63:0]            item_ext, rd_ext;
   logic [CW-1:0]          cur_step, last_idx;
   logic                   step_down;

   logic                   ram_wr_en, ram_rd_en;
   logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data, ram_rd_data;

   iidl_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   assign pos_x    = CMPW'(req_ch.position);
   assign cnt_x    = CMPW'(count_ff);
   // Sign-extend the request value, then keep the stored width.
   assign item_ext = 64'(req_ch.item_value);
   // Stored value back to the 32-bit result field, sign-extended.
   assign rd_ext   = 64'($signed(ram_rd_data));
   assign last_idx = CW'(count_ff - 1'b1);

   // Shared cursor stepper: walks down for insert, up for remove.
   assign step_down = (state_ff == S_INS_RD) || (state_ff == S_INS_WR);
   assign cur_step  = step_down ? CW'(cur_ff - 1'b1) : CW'(cur_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      val_in        = val_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff[AW-1:0];
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cur_step[AW-1:0];

      // Drop the response once the sink has taken it.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in   = req_ch.func;
               pos_in    = CW'(req_ch.position);
               val_in    = item_ext[VALUE_WIDTH-1:0];
               res_in    = '0;
               status_in = ST_OK;
               cur_in    = count_ff;
               if (req_ch.func == FUNC_INSERT) begin
                  if (pos_x > cnt_x) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else if (pos_x == cnt_x) begin
                     state_in = S_PUT;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end else if (pos_x >= cnt_x) begin
                  status_in = ST_RANGE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_INS_RD: begin
            // Fetch the entry just below the cursor.
            ram_rd_en = 1'b1;
            state_in  = S_INS_WR;
         end
         S_INS_WR: begin
            // Move it up into the cursor slot, then step down.
            ram_wr_en = 1'b1;
            cur_in    = cur_step;
            state_in  = (cur_step == pos_ff) ? S_PUT : S_INS_RD;
         end
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = val_ff;
            if (func_ff == FUNC_INSERT) begin
               count_in = CW'(count_ff + 1'b1);
            end
            state_in = S_DONE;
         end
         S_FETCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_ff[AW-1:0];
            state_in    = S_CAP;
         end
         S_CAP: begin
            res_in = rd_ext[IO_WIDTH-1:0];
            cur_in = pos_ff;
            case (func_ff)
               FUNC_WRITE: state_in = S_PUT;
               FUNC_REMOVE: begin
                  if (pos_ff == last_idx) begin
                     count_in = last_idx;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_DEL_RD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DEL_RD: begin
            // Fetch the entry just above the cursor.
            ram_rd_en = 1'b1;
            state_in  = S_DEL_WR;
         end
         S_DEL_WR: begin
            // Move it down into the cursor slot, then step up.
            ram_wr_en = 1'b1;
            cur_in    = cur_step;
            if (cur_step == last_idx) begin
               count_in = last_idx;
               state_in = S_DONE;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_DONE: begin
            // Hold until the response register is free, then publish.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               out_value_in  = res_ff;
               out_status_in = status_ff;
               out_count_in  = COUNT_WIDTH'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      val_ff        <= val_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_value  = out_value_ff;
   assign rsp_ch.status        = out_status_ff;
   assign rsp_ch.element_count = out_count_ff;

endmodule

@@ hdl/iidl_checker.sv @@
// Port-level checks for the indexed insert/delete list, bound to the top level.
// Depends on iidl_pkg and indexed_insert_delete_list.
module iidl_checker import iidl_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [IO_WIDTH-1:0]    result_value,
   input status_type             status,
   input logic [COUNT_WIDTH-1:0] element_count
);

   localparam logic [COUNT_WIDTH-1:0] CAP_CODE = COUNT_WIDTH'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value)
         && $stable(status) && $stable(element_count))
      else $error("response changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> result_value == '0)
      else $error("nonzero value on error response");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_FULL |-> element_count == CAP_CODE)
      else $error("full status with list not at capacity");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status == ST_OK || status == ST_RANGE || status == ST_FULL)
      else $error("undefined status code");

endmodule

bind indexed_insert_delete_list iidl_checker #(
   .CAPACITY (CAPACITY)
) u_iidl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .result_value  (rsp_ch.result_value),
   .status        (rsp_ch.status),
   .element_count (rsp_ch.element_count)
);

@@ tb/tb_indexed_insert_delete_list.sv @@
// Self-checking testbench for the indexed insert/delete list: directed corner
// requests, then biased random traffic, checked against an internal list model.
// Depends on iidl_pkg, iidl_if and the indexed_insert_delete_list RTL.
module tb_indexed_insert_delete_list;
   import iidl_pkg::*;

   localparam int CAPACITY    = DEF_CAPACITY;
   localparam int CLOCK_HALF  = 4;
   localparam int RANDOM_ITEMS = 1280;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   typedef logic signed [IO_WIDTH-1:0] word_type;
   typedef logic [POS_WIDTH-1:0]       index_type;

   // One response as the list should return it.
   typedef struct packed {
      word_type               value;
      status_type             status;
      logic [COUNT_WIDTH-1:0] count;
   } list_resp_type;

   // Shadow copy of the list. Predict each response when its request is
   // accepted, queue it, and compare it with the next response that arrives.
   class list_scoreboard;
      word_type      shadow[CAPACITY];
      int unsigned   live_count;
      list_resp_type awaited[$];
      int unsigned   mismatches;
      int unsigned   kind_seen[4];
      int unsigned   status_seen[4];
      int unsigned   peak;

      function new();
         live_count = 0;
         mismatches = 0;
         peak = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void note_request(func_type kind, index_type pos, word_type data);
         list_resp_type exp;
         exp.value = '0;
         exp.status = ST_OK;
         kind_seen[kind]++;
         if (kind == FUNC_INSERT) begin
            if (pos > live_count) begin
               exp.status = ST_RANGE;
            end else if (live_count >= CAPACITY) begin
               exp.status = ST_FULL;
            end else begin
               // open a slot at pos by moving the tail up one place
               for (int i = live_count; i > pos; i--) shadow[i] = shadow[i-1];
               shadow[pos] = data;
               live_count++;
            end
         end else if (pos >= live_count) begin
            exp.status = ST_RANGE;
         end else begin
            exp.value = shadow[pos];
            case (kind)
               FUNC_REMOVE: begin
                  for (int i = pos; i + 1 < live_count; i++) shadow[i] = shadow[i+1];
                  live_count--;
               end
               FUNC_WRITE: begin
                  shadow[pos] = data;
               end
               default: ;
            endcase
         end
         if (live_count > peak) peak = live_count;
         status_seen[exp.status]++;
         exp.count = live_count[COUNT_WIDTH-1:0];
         awaited.push_back(exp);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("ERROR: %s", what);
      endfunction

      function void check_response(list_resp_type got);
         list_resp_type exp;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected response value=%0d status=%0d count=%0d",
                           got.value, got.status, got.count));
            return;
         end
         exp = awaited.pop_front();
         if (got.value !== exp.value || got.status !== exp.status ||
             got.count !== exp.count)
            flag($sformatf("expected value=%0d status=%0d count=%0d, got value=%0d status=%0d count=%0d",
                           exp.value, exp.status, exp.count,
                           got.value, got.status, got.count));
      endfunction

      function void close_out();
         if (awaited.size() != 0)
            flag($sformatf("%0d responses never arrived", awaited.size()));
         mismatches += (awaited.size() > 1) ? awaited.size() - 1 : 0;
      endfunction
   endclass

   logic clock;
   logic reset;

   iidl_req_if req_ch ();
   iidl_rsp_if rsp_ch ();

   indexed_insert_delete_list #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (DEF_VALUE_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   list_scoreboard ledger;

   // Shared controls: steady turns idling off on both sides, hold_pending
   // asks the response side for one long hold-off.
   bit steady;
   bit hold_pending;

   initial begin
      clock = 1'b0;
   end

   always #CLOCK_HALF clock = ~clock;

   // Hard limit: far above the slowest legal run (every shift at full
   // length, every gap and stall at its longest).
   initial begin
      #(2 * CLOCK_HALF * 400000);
      $display("Mismatches found");
      $finish;
   end

   // Response side: check each transaction at the edge where valid and ready
   // meet, then choose ready for the next cycle.
   initial begin : response_side
      int unsigned   stall_left;
      list_resp_type got;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.value = rsp_ch.result_value;
            got.status = rsp_ch.status;
            got.count = rsp_ch.element_count;
            ledger.check_response(got);
         end
         if (stall_left == 0 && hold_pending) begin
            hold_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left != 0) begin
            // hold off; the sender keeps offering and the block backs up
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
         end
         @(posedge clock);
      end
   end

   // Offer one request, hold it until accepted, record it, then maybe idle.
   task automatic offer_request(input func_type kind, input index_type pos,
                                input word_type data);
      req_ch.valid <= 1'b1;
      req_ch.func <= kind;
      req_ch.position <= pos;
      req_ch.item_value <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ledger.note_request(kind, pos, data);
      if (!steady && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every outstanding response is back.
   task automatic drain_list();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   // Build one random request around the current length: mostly in-range
   // positions, some noise over the whole index field, extremes in the data.
   task automatic random_request();
      func_type    kind;
      index_type   pos;
      word_type    data;
      int unsigned n;
      int unsigned roll;
      int unsigned insert_w;
      int unsigned remove_w;
      n = ledger.live_count;
      insert_w = (n < 4) ? 60 : 35;
      remove_w = (n < 4) ? 10 : (n > 12) ? 35 : 30;
      roll = $urandom_range(0, 99);
      if (roll < insert_w) kind = FUNC_INSERT;
      else if (roll < insert_w + remove_w) kind = FUNC_REMOVE;
      else if (roll % 2 == 0) kind = FUNC_READ;
      else kind = FUNC_WRITE;
      if ($urandom_range(0, 99) < 10) pos = index_type'($urandom_range(0, 31));
      else if (kind == FUNC_INSERT) pos = index_type'($urandom_range(0, n));
      else if (n == 0) pos = '0;
      else pos = index_type'($urandom_range(0, n - 1));
      case ($urandom_range(0, 9))
         0: data = 32'sh8000_0000;
         1: data = 32'sh7FFF_FFFF;
         2: data = -32'sd1;
         3: data = '0;
         default: data = word_type'($urandom);
      endcase
      offer_request(kind, pos, data);
   endtask

   initial begin : stimulus
      ledger = new();
      steady = 1'b0;
      hold_pending = 1'b0;
      reset = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func <= FUNC_INSERT;
      req_ch.position <= '0;
      req_ch.item_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty list: every access is out of range, insert past the end too.
      offer_request(FUNC_READ, 5'd0, 32'sd0);
      offer_request(FUNC_REMOVE, 5'd0, 32'sd0);
      offer_request(FUNC_WRITE, 5'd0, 32'sd7);
      offer_request(FUNC_INSERT, 5'd1, 32'sd7);
      // Insert at the head, append, insert in the middle.
      offer_request(FUNC_INSERT, 5'd0, 32'sh7FFF_FFFF);
      offer_request(FUNC_INSERT, 5'd1, 32'sh8000_0000);
      offer_request(FUNC_INSERT, 5'd0, -32'sd1);
      offer_request(FUNC_INSERT, 5'd1, 32'sd0);
      offer_request(FUNC_READ, 5'd3, 32'sd0);
      offer_request(FUNC_WRITE, 5'd2, 32'sh5555_5555);
      offer_request(FUNC_REMOVE, 5'd1, 32'sd0);
      offer_request(FUNC_REMOVE, 5'd2, 32'sd0);
      offer_request(FUNC_REMOVE, 5'd0, 32'sd0);
      // Fill to capacity with appends, then probe the full list.
      while (ledger.live_count < CAPACITY)
         offer_request(FUNC_INSERT, index_type'(ledger.live_count), word_type'($urandom));
      offer_request(FUNC_INSERT, 5'd16, 32'sd1);
      offer_request(FUNC_INSERT, 5'd31, 32'sd1);
      offer_request(FUNC_READ, 5'd16, 32'sd0);
      offer_request(FUNC_READ, 5'd15, 32'sd0);
      offer_request(FUNC_REMOVE, 5'd0, 32'sd0);
      offer_request(FUNC_REMOVE, 5'd31, 32'sd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // ask for one long hold-off while requests keep coming
         if (n == 200) hold_pending = 1'b1;
         // stretch with no idling on either side
         if (n == 400) steady = 1'b1;
         if (n == 600) steady = 1'b0;
         // pause the sender until the block has answered everything
         if (n == 800) drain_list();
         random_request();
      end

      drain_list();
      repeat (50) @(posedge clock);
      ledger.close_out();

      $display("Run covered %0d requests: insert %0d, remove %0d, read %0d, write %0d; peak length %0d",
               ledger.kind_seen[FUNC_INSERT] + ledger.kind_seen[FUNC_REMOVE] +
               ledger.kind_seen[FUNC_READ] + ledger.kind_seen[FUNC_WRITE],
               ledger.kind_seen[FUNC_INSERT], ledger.kind_seen[FUNC_REMOVE],
               ledger.kind_seen[FUNC_READ], ledger.kind_seen[FUNC_WRITE], ledger.peak);
      $display("Statuses predicted: ok %0d, bad index %0d, list full %0d",
               ledger.status_seen[ST_OK], ledger.status_seen[ST_RANGE],
               ledger.status_seen[ST_FULL]);
      if (ledger.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
